FILE: rtl/dns_query_question_parser_core_defines.svh
// assertion macros shared by the dns question parser rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef DNS_QUERY_QUESTION_PARSER_CORE_DEFINES_SVH
`define DNS_QUERY_QUESTION_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DQQP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DQQP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dqqp_pkg.sv
// types and constants of the dns question parser
// no dependencies
package dqqp_pkg;

    localparam int unsigned MIN_PACKET_LEN = 17;
    localparam int unsigned MAX_LABEL_LEN  = 63;
    localparam int unsigned MAX_NAME_LEN   = 255;
    localparam int unsigned HEADER_LEN     = 12;

    // byte offset only matters below the short-packet bound, so it saturates there
    localparam int unsigned OFF_W = 5;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    localparam int unsigned RES_BITS = 83;
    localparam int unsigned TDATA_W  = 88;
    localparam int unsigned PAD_W    = TDATA_W - RES_BITS;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LENGTH = 3'd1,
        PH_LABEL  = 3'd2,
        PH_TAIL   = 3'd3,
        PH_DONE   = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_QDCOUNT = 3'd2,
        ST_LABEL   = 3'd3,
        ST_NAME    = 3'd4,
        ST_TRUNC   = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_char;
        status_t     status;
        logic [15:0] query_id;
        logic [15:0] header_flags;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic [7:0]  name_length;
        logic        last;
    } res_item_t;

    // up to two results per byte: item_a goes first
    typedef struct packed {
        logic      valid_a;
        logic      valid_b;
        res_item_t item_a;
        res_item_t item_b;
    } push_t;

endpackage

FILE: rtl/dqqp_parser.sv
// per-byte parse state and result generation of the dns question parser
// depends on dqqp_pkg and the shared assertion macros
`include "dns_query_question_parser_core_defines.svh"

module dqqp_parser
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  dqqp_pkg::in_item_t in_item,
    output dqqp_pkg::push_t    push
);

    dqqp_pkg::phase_t                phase_reg, phase_next;
    logic [dqqp_pkg::OFF_W-1:0]      off_reg, off_next;
    logic [5:0]                      lr_reg, lr_next;
    logic [7:0]                      chars_reg, chars_next;
    logic                            first_reg, first_next;
    dqqp_pkg::status_t               error_reg, error_next;
    logic [15:0]                     id_reg, id_next;
    logic [15:0]                     flags_reg, flags_next;
    logic [15:0]                     qd_reg, qd_next;
    logic [15:0]                     type_reg, type_next;
    logic [15:0]                     class_reg, class_next;

    logic [7:0]        b;
    logic [7:0]        chars_after;
    logic              char_valid;
    logic [7:0]        char_value;
    dqqp_pkg::status_t verdict;
    dqqp_pkg::res_item_t char_item;
    dqqp_pkg::res_item_t verdict_item;

    assign b = in_item.data_byte;

    // next state after this byte
    always_comb
    begin
        phase_next  = phase_reg;
        lr_next     = lr_reg;
        chars_next  = chars_reg;
        first_next  = first_reg;
        error_next  = error_reg;
        id_next     = id_reg;
        flags_next  = flags_reg;
        qd_next     = qd_reg;
        type_next   = type_reg;
        class_next  = class_reg;
        chars_after = first_reg ? chars_reg : chars_reg + 8'd1;

        unique case (phase_reg)
            dqqp_pkg::PH_HEADER:
            begin
                if (off_reg < dqqp_pkg::OFF_W'(2))
                    id_next = {id_reg[7:0], b};
                else if (off_reg < dqqp_pkg::OFF_W'(4))
                    flags_next = {flags_reg[7:0], b};
                else if (off_reg < dqqp_pkg::OFF_W'(6))
                    qd_next = {qd_reg[7:0], b};
                if (off_reg >= dqqp_pkg::OFF_W'(dqqp_pkg::HEADER_LEN - 1))
                begin
                    if (qd_reg != 16'd1)
                    begin
                        error_next = dqqp_pkg::ST_QDCOUNT;
                        phase_next = dqqp_pkg::PH_ERROR;
                    end
                    else
                    begin
                        phase_next = dqqp_pkg::PH_LENGTH;
                    end
                end
            end
            dqqp_pkg::PH_LENGTH:
            begin
                first_next = 1'b0;
                if (!first_reg && chars_reg >= 8'(dqqp_pkg::MAX_NAME_LEN))
                begin
                    // separating dot would pass the name limit
                    error_next = dqqp_pkg::ST_NAME;
                    phase_next = dqqp_pkg::PH_ERROR;
                end
                else if (b == 8'd0)
                begin
                    // root name gives one dot, else the closing dot
                    chars_next = first_reg ? 8'd1 : chars_after;
                    lr_next    = 6'd0;
                    phase_next = dqqp_pkg::PH_TAIL;
                end
                else
                begin
                    chars_next = chars_after;
                    if (b > 8'(dqqp_pkg::MAX_LABEL_LEN))
                    begin
                        error_next = dqqp_pkg::ST_LABEL;
                        phase_next = dqqp_pkg::PH_ERROR;
                    end
                    else if ({1'b0, chars_after} + {1'b0, b} > 9'(dqqp_pkg::MAX_NAME_LEN))
                    begin
                        error_next = dqqp_pkg::ST_NAME;
                        phase_next = dqqp_pkg::PH_ERROR;
                    end
                    else
                    begin
                        lr_next    = b[5:0];
                        phase_next = dqqp_pkg::PH_LABEL;
                    end
                end
            end
            dqqp_pkg::PH_LABEL:
            begin
                chars_next = chars_reg + 8'd1;
                lr_next    = lr_reg - 6'd1;
                if (lr_reg == 6'd1)
                    phase_next = dqqp_pkg::PH_LENGTH;
            end
            dqqp_pkg::PH_TAIL:
            begin
                if (lr_reg < 6'd2)
                    type_next = {type_reg[7:0], b};
                else
                    class_next = {class_reg[7:0], b};
                lr_next = lr_reg + 6'd1;
                if (lr_reg >= 6'd3)
                begin
                    lr_next    = 6'd0;
                    phase_next = dqqp_pkg::PH_DONE;
                end
            end
            default:
            begin
                // done or error: bytes are ignored
            end
        endcase

        if (off_reg == dqqp_pkg::OFF_W'(dqqp_pkg::MIN_PACKET_LEN))
            off_next = off_reg;
        else
            off_next = off_reg + dqqp_pkg::OFF_W'(1);
    end

    // name character output
    always_comb
    begin
        char_valid = 1'b0;
        char_value = b;
        unique case (phase_reg)
            dqqp_pkg::PH_LENGTH:
            begin
                char_value = dqqp_pkg::DOT_CHAR;
                if (first_reg)
                    char_valid = (b == 8'd0);
                else
                    char_valid = (chars_reg < 8'(dqqp_pkg::MAX_NAME_LEN));
            end
            dqqp_pkg::PH_LABEL:
            begin
                char_valid = 1'b1;
            end
            default:
            begin
                char_valid = 1'b0;
            end
        endcase
    end

    // verdict: short wins, then the first latched error, then truncation
    always_comb
    begin
        if (off_next < dqqp_pkg::OFF_W'(dqqp_pkg::MIN_PACKET_LEN))
            verdict = dqqp_pkg::ST_SHORT;
        else if (error_next != dqqp_pkg::ST_OK)
            verdict = error_next;
        else if (phase_next != dqqp_pkg::PH_DONE)
            verdict = dqqp_pkg::ST_TRUNC;
        else
            verdict = dqqp_pkg::ST_OK;
    end

    always_comb
    begin
        char_item              = '0;
        char_item.kind         = 1'b0;
        char_item.name_char    = char_value;
        char_item.status       = dqqp_pkg::ST_OK;

        verdict_item              = '0;
        verdict_item.kind         = 1'b1;
        verdict_item.status       = verdict;
        verdict_item.query_id     = id_next;
        verdict_item.header_flags = flags_next;
        verdict_item.query_type   = type_next;
        verdict_item.query_class  = class_next;
        verdict_item.name_length  = chars_next;
        verdict_item.last         = 1'b1;

        push.valid_a = advance && (char_valid || in_item.end_of_packet);
        push.valid_b = advance && char_valid && in_item.end_of_packet;
        push.item_a  = char_valid ? char_item : verdict_item;
        push.item_b  = verdict_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dqqp_pkg::PH_HEADER;
            off_reg   <= '0;
            lr_reg    <= '0;
            chars_reg <= '0;
            first_reg <= 1'b1;
            error_reg <= dqqp_pkg::ST_OK;
            id_reg    <= '0;
            flags_reg <= '0;
            qd_reg    <= '0;
            type_reg  <= '0;
            class_reg <= '0;
        end
        else if (advance)
        begin
            if (in_item.end_of_packet)
            begin
                // packet closed: back to the state after reset
                phase_reg <= dqqp_pkg::PH_HEADER;
                off_reg   <= '0;
                lr_reg    <= '0;
                chars_reg <= '0;
                first_reg <= 1'b1;
                error_reg <= dqqp_pkg::ST_OK;
                id_reg    <= '0;
                flags_reg <= '0;
                qd_reg    <= '0;
                type_reg  <= '0;
                class_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                off_reg   <= off_next;
                lr_reg    <= lr_next;
                chars_reg <= chars_next;
                first_reg <= first_next;
                error_reg <= error_next;
                id_reg    <= id_next;
                flags_reg <= flags_next;
                qd_reg    <= qd_next;
                type_reg  <= type_next;
                class_reg <= class_next;
            end
        end
    end

    `DQQP_ASSERT_SAME(a_error_latched, phase_reg == dqqp_pkg::PH_ERROR, error_reg != dqqp_pkg::ST_OK, "error phase without error code")
    `DQQP_ASSERT_SAME(a_label_count, phase_reg == dqqp_pkg::PH_LABEL, lr_reg != 6'd0, "label phase with nothing left")
    `DQQP_ASSERT_NEXT(a_hold_idle, !advance, $stable(chars_reg) && $stable(phase_reg), "state moved without a byte")

endmodule

FILE: rtl/dqqp_result_queue.sv
// four-entry result queue taking up to two results and giving one per cycle while out_ready is high
// depends on dqqp_pkg and the shared assertion macros
`include "dns_query_question_parser_core_defines.svh"

module dqqp_result_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  dqqp_pkg::push_t     push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output dqqp_pkg::res_item_t out_item
);

    dqqp_pkg::res_item_t             entry_reg [dqqp_pkg::QUEUE_DEPTH];
    logic [dqqp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dqqp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dqqp_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic [dqqp_pkg::QPTR_W-1:0]     wr_ptr_b;
    logic                            pop;

    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= dqqp_pkg::QCNT_W'(dqqp_pkg::QUEUE_DEPTH - 2));
    assign wr_ptr_b  = wr_ptr_reg + dqqp_pkg::QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + dqqp_pkg::QPTR_W'(push.valid_a)
                                 + dqqp_pkg::QPTR_W'(push.valid_b);
        rd_ptr_next = rd_ptr_reg + dqqp_pkg::QPTR_W'(pop);
        count_next  = count_reg + dqqp_pkg::QCNT_W'(push.valid_a)
                                + dqqp_pkg::QCNT_W'(push.valid_b)
                                - dqqp_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload entries, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < dqqp_pkg::QUEUE_DEPTH; i++)
        begin
            if (push.valid_a && wr_ptr_reg == dqqp_pkg::QPTR_W'(i))
                entry_reg[i] <= push.item_a;
            else if (push.valid_b && wr_ptr_b == dqqp_pkg::QPTR_W'(i))
                entry_reg[i] <= push.item_b;
        end
    end

    `DQQP_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= dqqp_pkg::QCNT_W'(dqqp_pkg::QUEUE_DEPTH), "queue count past depth")
    `DQQP_ASSERT_SAME(a_push_order, push.valid_b, push.valid_a, "second result without a first")
    `DQQP_ASSERT_SAME(a_push_room, push.valid_a, room, "push into a queue without room for two")

endmodule

FILE: rtl/dns_query_question_parser_core.sv
// top level of the dns query question parser
// depends on dqqp_pkg, dqqp_parser and dqqp_result_queue

// Parses a DNS query one byte per request on the slave stream: the header id,
// flags and question count (which must be one), then the question name, whose
// dotted text is streamed out one character per result as the labels go by,
// then the type and class. The last byte of a packet (s_axis_tlast) produces
// one verdict result (m_axis_tuser high, m_axis_tlast high) with the status,
// the captured header fields, type, class and the name length; the parser then
// starts over for the next packet. Bytes after the class are ignored. The
// block takes one byte per cycle while the result queue has room: a byte
// passes an input register, then the combinational parse logic, then a
// four-entry result queue that drains one result per cycle while
// m_axis_tready is high. A byte gives at most one name character, so a
// stream of bytes flows at full rate while the output is ready; only the
// final byte of a packet can give two results (the closing name character
// and the verdict), which can hold the input back when the output is stalled.
module dns_query_question_parser_core
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // data_byte
    input  logic                         s_axis_tlast,   // end_of_packet

    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // name_char, status, query_id, header_flags, query_type, query_class,
    // name_length, zero fill
    output logic [dqqp_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic                         m_axis_tuser,   // kind
    output logic                         m_axis_tlast    // last
);

    // input register in front of the parse logic
    logic               in_valid_reg;
    dqqp_pkg::in_item_t in_item_reg;

    logic                room;
    logic                advance;
    dqqp_pkg::push_t     push;
    dqqp_pkg::res_item_t out_item;

    // a byte moves on when the queue can take both possible results
    assign advance       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // payload capture, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.data_byte     <= s_axis_tdata;
            in_item_reg.end_of_packet <= s_axis_tlast;
        end
    end

    dqqp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_item (in_item_reg),
        .push    (push)
    );

    dqqp_result_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (out_item)
    );

    // pack the result fields, first field lowest
    assign m_axis_tdata = {
        {dqqp_pkg::PAD_W{1'b0}},
        out_item.name_length,
        out_item.query_class,
        out_item.query_type,
        out_item.header_flags,
        out_item.query_id,
        out_item.status,
        out_item.name_char
    };
    assign m_axis_tuser = out_item.kind;
    assign m_axis_tlast = out_item.last;

endmodule
